### sv/hpa_pkg.sv
// shared types and codes for the handle pool allocator
package hpa_pkg;

  localparam logic OP_GET    = 1'b0;
  localparam logic OP_RETURN = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED  = 2'd1;
  localparam logic [1:0] STATUS_NOT_IN_USE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic commit;
  } hpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } hpa_sts_t;

endpackage

### sv/hpa_intf.sv
// request and response channel interfaces of the handle pool allocator
interface hpa_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] handle_in;

  modport source (output valid, output opcode, output handle_in, input ready);
  modport sink (input valid, input opcode, input handle_in, output ready);
endinterface

interface hpa_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] handle_out;
  logic       exhausted;

  modport source (output valid, output status, output handle_out, output exhausted,
                  input ready);
  modport sink (input valid, input status, input handle_out, input exhausted,
                output ready);
endinterface

### sv/hpa_ctrl.sv
// sequencing state machine of the handle pool allocator
module hpa_ctrl import hpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hpa_sts_t sts,
  output hpa_cmd_t cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready     = (state_r == S_IDLE);
  assign cmd.clear_wr = (state_r == S_CLEAR);
  assign cmd.accept   = in_valid && (state_r == S_IDLE);
  assign cmd.commit   = (state_r == S_EXEC) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

endmodule

### sv/hpa_dp.sv
// free list memory, in-use marks, pointers and result register
module hpa_dp import hpa_pkg::*; #(
  parameter int POOL_SIZE = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  hpa_cmd_t   cmd,
  output hpa_sts_t   sts,
  input  logic       opcode,
  input  logic [3:0] handle_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [3:0] handle_out,
  output logic       exhausted
);

  localparam int AW   = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW   = $clog2(POOL_SIZE + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;
  localparam int GXW  = (AW > 4) ? AW : 4;

  logic [AW-1:0] free_queue [POOL_SIZE];
  logic          in_use     [POOL_SIZE];

  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] wr_ptr_r;
  logic [CW-1:0] free_cnt_r;
  logic [CW-1:0] free_cnt_nxt;

  logic          op_r;
  logic [AW-1:0] h_r;
  logic          h_ok_r;
  logic [AW-1:0] q_rd_r;
  logic          m_rd_r;

  logic          out_valid_r;
  logic [1:0]    status_r;
  logic [3:0]    handle_r;
  logic          exhausted_r;

  logic [CMPW-1:0] h_cmp;
  logic [AW-1:0]   h_idx;
  logic            get_ok;
  logic            ret_ok;
  logic [GXW-1:0]  g_ext;
  logic [1:0]      status_nxt;

  logic          q_we;
  logic [AW-1:0] q_wa;
  logic [AW-1:0] q_wd;
  logic          m_we;
  logic [AW-1:0] m_wa;
  logic          m_wd;

  assign h_cmp = CMPW'(handle_in);
  assign h_idx = h_cmp[AW-1:0];

  assign sts.clear_last = (clr_cnt_r == AW'(POOL_SIZE - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  // decision on the captured request and the registered reads
  assign get_ok = (op_r == OP_GET) && (free_cnt_r != '0);
  assign ret_ok = (op_r == OP_RETURN) && h_ok_r && m_rd_r &&
                  (free_cnt_r < CW'(POOL_SIZE));
  assign g_ext  = GXW'(q_rd_r);

  always_comb begin
    free_cnt_nxt = free_cnt_r;
    status_nxt   = STATUS_OK;
    if (get_ok) free_cnt_nxt = free_cnt_r - 1'b1;
    else if (ret_ok) free_cnt_nxt = free_cnt_r + 1'b1;
    if (op_r == OP_GET) begin
      if (!get_ok) status_nxt = STATUS_EXHAUSTED;
    end else begin
      if (!ret_ok) status_nxt = STATUS_NOT_IN_USE;
    end
  end

  // single write port per memory, shared by the clearing pass
  always_comb begin
    q_we = 1'b0;
    q_wa = wr_ptr_r;
    q_wd = h_r;
    m_we = 1'b0;
    m_wa = h_r;
    m_wd = 1'b0;
    if (cmd.clear_wr) begin
      q_we = 1'b1;
      q_wa = clr_cnt_r;
      q_wd = clr_cnt_r;
      m_we = 1'b1;
      m_wa = clr_cnt_r;
    end else if (cmd.commit && get_ok) begin
      m_we = 1'b1;
      m_wa = q_rd_r;
      m_wd = 1'b1;
    end else if (cmd.commit && ret_ok) begin
      q_we = 1'b1;
      m_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) free_queue[q_wa] <= q_wd;
    if (cmd.accept) q_rd_r <= free_queue[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (m_we) in_use[m_wa] <= m_wd;
    if (cmd.accept) m_rd_r <= in_use[h_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= opcode;
      h_r    <= h_idx;
      h_ok_r <= (h_cmp < CMPW'(POOL_SIZE));
    end
    if (cmd.commit) begin
      status_r    <= status_nxt;
      handle_r    <= get_ok ? g_ext[3:0] : 4'd0;
      exhausted_r <= (free_cnt_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      free_cnt_r  <= CW'(POOL_SIZE);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.commit) begin
        free_cnt_r <= free_cnt_nxt;
        if (get_ok) rd_ptr_r <= (rd_ptr_r == AW'(POOL_SIZE - 1)) ? '0 : rd_ptr_r + 1'b1;
        if (ret_ok) wr_ptr_r <= (wr_ptr_r == AW'(POOL_SIZE - 1)) ? '0 : wr_ptr_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign status     = status_r;
  assign handle_out = handle_r;
  assign exhausted  = exhausted_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CW'(POOL_SIZE))
    else $error("free count above pool size");

  a_get_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && get_ok |=> free_cnt_r == $past(free_cnt_r) - 1'b1)
    else $error("granted get did not take a free handle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("result register overwritten before it was taken");

  a_exh_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> exhausted_r == (free_cnt_r == '0))
    else $error("exhausted flag disagrees with free count");
`endif

endmodule

### sv/handle_pool_allocator_unit.sv
// top level of the handle pool allocator: fifo free list of slot handles
// a request beat is captured along with registered reads of the free list
// and mark memories, then committed into the result register once it is
// free; the next request is taken only after the last one is committed
// reset: synchronous, active low; then a clearing pass loads the free list
// with 0..POOL_SIZE-1 and clears all marks, ready low
module handle_pool_allocator_unit import hpa_pkg::*; #(
  parameter int POOL_SIZE = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  hpa_req_if.sink   in_ch,
  hpa_rsp_if.source out_ch
);

  // command and status between the sequencer and the datapath
  hpa_cmd_t cmd;
  hpa_sts_t sts;

  // sequencer: clearing pass, request capture, commit into result register
  hpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: free list memory, in-use marks, pointers, count, result beat
  hpa_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (in_ch.opcode),
    .handle_in  (in_ch.handle_in),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (out_ch.status),
    .handle_out (out_ch.handle_out),
    .exhausted  (out_ch.exhausted)
  );

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for the handle pool allocator: directed and random request traffic
`timescale 1ns / 100ps

module tb_top;
  import hpa_pkg::*;

  localparam int POOL_SIZE    = 16;
  localparam int CLK_HALF     = 6;       // 12 ns clock period
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_OFF_LEN = 400;     // long result-side stall for the pressure test
  localparam int TAIL_CYCLES  = 20;      // settle time after the last expected result
  localparam int CYCLE_LIMIT  = 800000;  // generous run limit, several times the slowest run

  // one result beat as the block should present it
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] handle_out;
    logic       exhausted;
  } pool_result_t;

  logic clk;
  logic rst_n;

  hpa_req_if req_ch ();
  hpa_rsp_if rsp_ch ();

  handle_pool_allocator_unit #(.POOL_SIZE(POOL_SIZE)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  // --------------------------------------------------------------------
  // pool model: fifo free list of handles plus one busy mark per handle
  // --------------------------------------------------------------------
  logic [3:0] free_list [POOL_SIZE];
  logic [3:0] head_ptr;
  logic [3:0] tail_ptr;
  logic [4:0] free_total;
  logic       handle_busy [POOL_SIZE];

  pool_result_t pool_results_due[$];  // results owed by the block, oldest first
  int           mismatch_count = 0;
  int           cycle_count = 0;

  // knobs shared with the traffic processes
  bit no_idle = 1'b0;         // when set neither side inserts gaps
  int hold_requests = 0;      // bumped by a test to ask for one long result stall
  int hold_served = 0;

  function automatic logic [3:0] wrap_inc(input logic [3:0] p);
    return (int'(p) == POOL_SIZE - 1) ? 4'd0 : p + 4'd1;
  endfunction

  // after reset the free list holds 0..POOL_SIZE-1 in order, nothing busy
  function automatic void reset_pool_model();
    for (int k = 0; k < POOL_SIZE; k++) begin
      free_list[k]   = 4'(k);
      handle_busy[k] = 1'b0;
    end
    head_ptr   = '0;
    tail_ptr   = '0;
    free_total = 5'(POOL_SIZE);
  endfunction

  // apply one accepted request to the model and return the owed result
  function automatic pool_result_t predict_pool_step(input logic op, input logic [3:0] h);
    pool_result_t res;
    logic [3:0]   granted;
    res = '{status: STATUS_OK, handle_out: 4'd0, exhausted: 1'b0};
    if (op == OP_GET) begin
      if (free_total == 0) begin
        // empty pool: refuse, nothing moves
        res.status = STATUS_EXHAUSTED;
      end else begin
        granted              = free_list[head_ptr];
        head_ptr             = wrap_inc(head_ptr);
        free_total           = free_total - 5'd1;
        handle_busy[granted] = 1'b1;
        res.handle_out       = granted;
      end
    end else begin
      // out-of-range, idle handle or full pool: bad return, nothing moves
      if (int'(h) >= POOL_SIZE || !handle_busy[h] || int'(free_total) >= POOL_SIZE) begin
        res.status = STATUS_NOT_IN_USE;
      end else begin
        handle_busy[h]      = 1'b0;
        free_list[tail_ptr] = h;
        tail_ptr            = wrap_inc(tail_ptr);
        free_total          = free_total + 5'd1;
      end
    end
    res.exhausted = (free_total == 0);
    return res;
  endfunction

  // --------------------------------------------------------------------
  // clock, reset and run limit
  // --------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("handle_pool_allocator_unit regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------
  // gap lengths: mostly none or short, now and then a long one
  // --------------------------------------------------------------------
  function automatic int pick_send_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_stall_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // --------------------------------------------------------------------
  // result side: ready pattern, with a long hold-off on request
  // --------------------------------------------------------------------
  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_requests != hold_served) begin
        // long stall counted here so the block backs up into the request side
        hold_served++;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else if (no_idle || $urandom_range(0, 99) < 65) begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat (pick_stall_len()) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------
  // result checker: every result beat against the oldest owed result
  // --------------------------------------------------------------------
  always @(posedge clk) begin
    pool_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pool_results_due.size() == 0) begin
        $error("result beat with no request outstanding: status=%0d handle_out=%0d",
               rsp_ch.status, rsp_ch.handle_out);
        mismatch_count++;
      end else begin
        want = pool_results_due[0];
        pool_results_due.delete(0);
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.handle_out !== want.handle_out) begin
          $error("handle_out: expected %0d, got %0d", want.handle_out, rsp_ch.handle_out);
          mismatch_count++;
        end
        if (rsp_ch.exhausted !== want.exhausted) begin
          $error("exhausted: expected %0b, got %0b", want.exhausted, rsp_ch.exhausted);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------
  // offer one request beat, hold it until accepted, then book its result;
  // valid stays high when the next beat follows with no gap
  task automatic send_request(input logic op, input logic [3:0] h);
    int gap;
    gap = pick_send_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.opcode    <= op;
    req_ch.handle_in <= h;
    do @(posedge clk); while (!req_ch.ready);
    pool_results_due.push_back(predict_pool_step(op, h));
  endtask

  // drop valid and let every owed result come back
  task automatic finish_phase();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pool_results_due.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed traffic: gets, and returns of handles really held;
  // a tenth is noise (random opcode and handle, so bad returns show up)
  task automatic choose_request(input int get_pct, output logic op, output logic [3:0] h);
    logic [3:0] held[$];
    for (int k = 0; k < POOL_SIZE; k++)
      if (handle_busy[k]) held.push_back(4'(k));
    h = 4'($urandom);
    if ($urandom_range(0, 99) < 10) begin
      op = 1'($urandom);
    end else if (held.size() != 0 && $urandom_range(0, 99) >= get_pct) begin
      op = OP_RETURN;
      h  = held[$urandom_range(0, held.size() - 1)];
    end else begin
      op = OP_GET;
    end
  endtask

  // --------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------
  // boundary walk: bad returns on a full pool, drain to empty, get on empty,
  // good and repeated returns, then recycling of the returned handle
  task automatic test_directed_edges();
    send_request(OP_RETURN, 4'd5);    // nothing held yet
    send_request(OP_RETURN, 4'd15);
    for (int k = 0; k < POOL_SIZE; k++)
      send_request(OP_GET, (k % 2 == 0) ? 4'hF : 4'h0);  // handle_in ignored on get
    send_request(OP_GET, 4'hA);       // pool empty
    send_request(OP_RETURN, 4'd3);
    send_request(OP_RETURN, 4'd3);    // already back on the free list
    send_request(OP_GET, 4'd0);       // should grant 3 again
    finish_phase();
  endtask

  // random traffic whose get/return mix shifts so the pool swings
  // between full and empty
  task automatic test_mixed_traffic(input int n_items);
    int         get_pct;
    logic       op;
    logic [3:0] h;
    get_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       get_pct = 15;
          1:       get_pct = 50;
          default: get_pct = 88;
        endcase
      end
      choose_request(get_pct, op, h);
      send_request(op, h);
    end
    finish_phase();
  endtask

  // back-to-back beats on both sides at full rate
  task automatic test_steady_stream(input int n_items);
    logic       op;
    logic [3:0] h;
    no_idle = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      choose_request(50, op, h);
      send_request(op, h);
    end
    finish_phase();
    no_idle = 1'b0;
  endtask

  // result side holds off for a long stretch while requests keep coming,
  // so the block fills up and drops ready on the request side
  task automatic test_back_pressure(input int n_items);
    logic       op;
    logic [3:0] h;
    hold_requests++;
    for (int i = 0; i < n_items; i++) begin
      choose_request(60, op, h);
      send_request(op, h);
    end
    finish_phase();
  endtask

  // --------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.opcode    = OP_GET;
    req_ch.handle_in = 4'd0;
    reset_pool_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ready stays low through the clearing pass; send_request waits on it
    test_directed_edges();
    test_mixed_traffic(900);
    test_back_pressure(120);
    test_steady_stream(250);
    test_mixed_traffic(600);
    test_back_pressure(60);

    finish_phase();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pool_results_due.size() == 0) begin
      $display("handle_pool_allocator_unit regression: pass");
    end else begin
      $display("handle_pool_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule
